// File: hdl/tscd_pkg.sv
// Shared types, constants and helper functions for the triple synced clock divider.
// No dependencies; imported by the front, back and top modules of the block.
package tscd_pkg;

  localparam int unsigned NUM_GEN    = 3;
  localparam int unsigned GEN_A      = 0;
  localparam int unsigned GEN_B      = 1;
  localparam int unsigned GEN_C      = 2;

  localparam int unsigned SEL_W      = 4;
  localparam int unsigned NUM_SEL    = 11;
  localparam logic [SEL_W-1:0] SEL_RESET = SEL_W'(5);

  localparam int unsigned POS_W      = 16;
  localparam int unsigned LIM_W      = 11;
  localparam int unsigned DUTY_W     = 3;
  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(6);

  // Generator A has a fixed length of 48 steps.
  localparam int unsigned A_TICKS    = 48;
  localparam logic [LIM_W-1:0]  A_LIMIT = LIM_W'(A_TICKS - 1);
  localparam logic [DUTY_W-1:0] A_DUTY  = DUTY_W'(6);

  // Master period = DIVIDEND / (knob_a*2/3 + A_OFFSET)
  localparam int unsigned DIVIDEND   = 8160 * 1000 / A_TICKS;
  localparam int unsigned A_OFFSET   = 666;
  localparam int unsigned DIVISOR_W  = 11;
  localparam int unsigned QUOT_W     = 8;
  localparam int unsigned REM_W      = DIVISOR_W;
  localparam logic [REM_W-1:0]  DIV_HI = REM_W'(DIVIDEND >> QUOT_W);
  localparam logic [QUOT_W-1:0] DIV_LO = QUOT_W'(DIVIDEND % (1 << QUOT_W));

  // x/3 as (x * RECIP3) >> RECIP3_SH, exact for x below 8192
  localparam int unsigned RECIP3_SH  = 13;
  localparam logic [11:0] RECIP3     = 12'd2731;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_KNOB = 1'b1
  } kind_e;

  // One classified item travelling from front to back.
  typedef struct packed {
    kind_e                kind;
    logic [SEL_W-1:0]     sel_b;
    logic [SEL_W-1:0]     sel_c;
    logic [DIVISOR_W-1:0] divisor;
  } tscd_item_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             level;
    logic             wrap;
  } gen_state_t;

  typedef struct packed {
    logic [LIM_W-1:0]  limit;
    logic [DUTY_W-1:0] duty;
  } gen_len_t;

  function automatic logic [LIM_W-1:0] mul_ticks_b(input logic [SEL_W-1:0] sel);
    logic [LIM_W-1:0] t;
    case (sel)
      4'd0:    t = 11'd288;
      4'd1:    t = 11'd240;
      4'd2:    t = 11'd192;
      4'd3:    t = 11'd144;
      4'd4:    t = 11'd96;
      4'd5:    t = 11'd48;
      4'd6:    t = 11'd24;
      4'd7:    t = 11'd16;
      4'd8:    t = 11'd12;
      4'd9:    t = 11'd9;
      default: t = 11'd8;
    endcase
    return t;
  endfunction

  function automatic logic [LIM_W-1:0] mul_ticks_c(input logic [SEL_W-1:0] sel);
    logic [LIM_W-1:0] t;
    case (sel)
      4'd0:    t = 11'd1152;
      4'd1:    t = 11'd768;
      4'd2:    t = 11'd384;
      4'd3:    t = 11'd192;
      4'd4:    t = 11'd96;
      4'd5:    t = 11'd48;
      4'd6:    t = 11'd24;
      4'd7:    t = 11'd12;
      4'd8:    t = 11'd6;
      4'd9:    t = 11'd3;
      default: t = 11'd2;
    endcase
    return t;
  endfunction

  // duty = min(6, ticks/2), limit = ticks - 1
  function automatic gen_len_t length_of(input logic [LIM_W-1:0] ticks);
    gen_len_t         r;
    logic [LIM_W-1:0] half;
    half    = ticks >> 1;
    r.duty  = (half < LIM_W'(DUTY_MAX)) ? half[DUTY_W-1:0] : DUTY_MAX;
    r.limit = ticks - LIM_W'(1);
    return r;
  endfunction

  function automatic gen_state_t gen_step(input logic [POS_W-1:0]  pos,
                                          input logic              level,
                                          input logic [DUTY_W-1:0] duty,
                                          input logic [LIM_W-1:0]  limit);
    gen_state_t r;
    r.pos   = pos + POS_W'(1);
    r.level = level;
    r.wrap  = 1'b0;
    if (r.pos == POS_W'(duty)) begin
      r.level = 1'b0;
    end
    if (r.pos > POS_W'(limit)) begin
      r.pos   = '0;
      r.level = 1'b1;
      r.wrap  = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: hdl/tscd_fifo.sv
// Small first-in first-out queue held in flops, one write and one read port.
// Used between front and back and at the result side; no package needed.
module tscd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hdl/tscd_front.sv
// Front end: classifies an incoming item, maps the knobs to table indexes and
// the master-rate divisor. Depends on tscd_pkg.
module tscd_front #(
  parameter int unsigned ADC_RANGE = 1024
) (
  input  logic                kind_i,
  input  logic [9:0]          knob_a_i,
  input  logic [9:0]          knob_b_i,
  input  logic [9:0]          knob_c_i,
  output tscd_pkg::tscd_item_t item_o
);
  import tscd_pkg::*;

  // index = min(10, knob*11/ADC_RANGE), by compare against k*ADC_RANGE
  function automatic logic [SEL_W-1:0] table_index(input logic [9:0] knob);
    logic [13:0]      scaled;
    logic [SEL_W-1:0] idx;
    scaled = 14'(knob) * 14'(NUM_SEL);
    idx    = '0;
    for (int k = 1; k < NUM_SEL; k++) begin
      if (32'(scaled) >= 32'(k * ADC_RANGE)) begin
        idx = SEL_W'(k);
      end
    end
    return idx;
  endfunction

  logic [10:0] knob_a2;
  logic [22:0] recip_prod;
  logic [9:0]  third;

  assign knob_a2    = {knob_a_i, 1'b0};
  assign recip_prod = 23'(knob_a2) * 23'(RECIP3);
  assign third      = recip_prod[RECIP3_SH +: 10];

  always_comb begin
    item_o.kind    = kind_e'(kind_i);
    item_o.sel_b   = table_index(knob_b_i);
    item_o.sel_c   = table_index(knob_c_i);
    item_o.divisor = DIVISOR_W'(third) + DIVISOR_W'(A_OFFSET);
  end

endmodule

// File: hdl/tscd_back.sv
// Back end: master counter, the three pulse generators, and the bit-serial
// divider for the master period. Depends on tscd_pkg.
module tscd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tscd_pkg::tscd_item_t item_i,
  input  logic                 item_empty_i,
  output logic                 item_pop_o,
  output logic                 res_push_o,
  output logic [2:0]           res_o,
  input  logic                 res_full_i
);
  import tscd_pkg::*;

  localparam int unsigned STEP_W = $clog2(QUOT_W);

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } state_e;

  state_e                 state_q, state_d;
  logic [POS_W-1:0]       mcount_q, mcount_d;
  logic [POS_W-1:0]       mlimit_q, mlimit_d;
  logic [POS_W-1:0]       pos_q   [NUM_GEN];
  logic [POS_W-1:0]       pos_d   [NUM_GEN];
  logic [NUM_GEN-1:0]     level_q, level_d;
  gen_len_t               len_q   [NUM_GEN];
  gen_len_t               len_d   [NUM_GEN];
  logic [SEL_W-1:0]       sel_b_q, sel_b_d;
  logic [SEL_W-1:0]       sel_c_q, sel_c_d;
  logic [1:0]             resync_q, resync_d;

  logic [REM_W-1:0]       rem_q, rem_d;
  logic [QUOT_W-1:0]      quot_q, quot_d;
  logic [DIVISOR_W-1:0]   dvsr_q, dvsr_d;
  logic [STEP_W-1:0]      step_q, step_d;

  logic                   take;
  logic [POS_W-1:0]       mcount_inc;
  gen_state_t             st_a, st_b, st_c;
  logic [POS_W-1:0]       pre_b_pos, pre_c_pos;
  logic                   pre_b_lvl, pre_c_lvl;
  logic [REM_W:0]         trial;
  logic                   ge;
  logic [QUOT_W-1:0]      quot_next;

  assign take       = (state_q == ST_RUN) && !item_empty_i && !res_full_i;
  assign item_pop_o = take;
  assign mcount_inc = mcount_q + POS_W'(1);

  // A steps first; when it wraps, flagged generators restart at 0xFFFF, on.
  always_comb begin
    st_a      = gen_step(pos_q[GEN_A], level_q[GEN_A], len_q[GEN_A].duty, len_q[GEN_A].limit);
    pre_b_pos = pos_q[GEN_B];
    pre_b_lvl = level_q[GEN_B];
    pre_c_pos = pos_q[GEN_C];
    pre_c_lvl = level_q[GEN_C];
    if (st_a.wrap && resync_q[0]) begin
      pre_b_pos = '1;
      pre_b_lvl = 1'b1;
    end
    if (st_a.wrap && resync_q[1]) begin
      pre_c_pos = '1;
      pre_c_lvl = 1'b1;
    end
    st_b = gen_step(pre_b_pos, pre_b_lvl, len_q[GEN_B].duty, len_q[GEN_B].limit);
    st_c = gen_step(pre_c_pos, pre_c_lvl, len_q[GEN_C].duty, len_q[GEN_C].limit);
  end

  assign trial     = {rem_q, DIV_LO[step_q]};
  assign ge        = (trial >= (REM_W + 1)'(dvsr_q));
  assign quot_next = {quot_q[QUOT_W-2:0], ge};

  always_comb begin
    state_d    = state_q;
    mcount_d   = mcount_q;
    mlimit_d   = mlimit_q;
    pos_d      = pos_q;
    level_d    = level_q;
    len_d      = len_q;
    sel_b_d    = sel_b_q;
    sel_c_d    = sel_c_q;
    resync_d   = resync_q;
    rem_d      = rem_q;
    quot_d     = quot_q;
    dvsr_d     = dvsr_q;
    step_d     = step_q;
    res_push_o = 1'b0;
    res_o      = level_q;

    case (state_q)
      ST_RUN: begin
        if (take && item_i.kind == KIND_TICK) begin
          res_push_o = 1'b1;
          if (mcount_inc > mlimit_q) begin
            mcount_d       = '0;
            pos_d[GEN_A]   = st_a.pos;
            pos_d[GEN_B]   = st_b.pos;
            pos_d[GEN_C]   = st_c.pos;
            level_d        = {st_c.level, st_b.level, st_a.level};
            if (st_a.wrap) begin
              resync_d = '0;
            end
            res_o = {st_c.level, st_b.level, st_a.level};
          end else begin
            mcount_d = mcount_inc;
          end
        end else if (take) begin
          if (item_i.sel_b != sel_b_q) begin
            sel_b_d     = item_i.sel_b;
            resync_d[0] = 1'b1;
          end
          if (item_i.sel_c != sel_c_q) begin
            sel_c_d     = item_i.sel_c;
            resync_d[1] = 1'b1;
          end
          len_d[GEN_B] = length_of(mul_ticks_b(item_i.sel_b));
          len_d[GEN_C] = length_of(mul_ticks_c(item_i.sel_c));
          rem_d        = DIV_HI;
          quot_d       = '0;
          dvsr_d       = item_i.divisor;
          step_d       = '1;
          state_d      = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = ge ? REM_W'(trial - (REM_W + 1)'(dvsr_q)) : trial[REM_W-1:0];
        quot_d = quot_next;
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          // result queue had room when the knob item was taken
          mlimit_d   = POS_W'(quot_next);
          res_push_o = 1'b1;
          state_d    = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      mcount_q     <= '0;
      mlimit_q     <= '0;
      pos_q        <= '{default: '0};
      level_q      <= '1;
      len_q[GEN_A] <= '{limit: A_LIMIT, duty: A_DUTY};
      len_q[GEN_B] <= '0;
      len_q[GEN_C] <= '0;
      sel_b_q      <= SEL_RESET;
      sel_c_q      <= SEL_RESET;
      resync_q     <= '0;
    end else begin
      state_q  <= state_d;
      mcount_q <= mcount_d;
      mlimit_q <= mlimit_d;
      pos_q    <= pos_d;
      level_q  <= level_d;
      len_q    <= len_d;
      sel_b_q  <= sel_b_d;
      sel_c_q  <= sel_c_d;
      resync_q <= resync_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvsr_q <= dvsr_d;
    step_q <= step_d;
  end

endmodule

// File: hdl/triple_synced_clock_divider_core.sv
// Triple synced clock divider. Tick items advance a master counter; each time it
// passes its period, pulse generators A, B and C step once, and every item yields
// one result with the three output levels after it. Ticks sustain one per cycle while
// items wait and the result queue has room; a knob item holds the back end, taking no
// other item, through the eight quotient-bit steps of the serial divider that forms the
// master period. Input and result queues of two entries each let both sides stall
// independently. Depends on tscd_pkg, tscd_front, tscd_fifo, tscd_back.
module triple_synced_clock_divider_core #(
  parameter int unsigned ADC_RANGE = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       kind_i,
  input  logic [9:0] knob_a_i,
  input  logic [9:0] knob_b_i,
  input  logic [9:0] knob_c_i,
  input  logic       pop,
  output logic       empty,
  output logic       out_a_o,
  output logic       out_b_o,
  output logic       out_c_o
);
  import tscd_pkg::*;

  tscd_item_t front_item, back_item;
  logic       item_empty, item_pop;
  logic       res_push, res_full;
  logic [2:0] res_in, res_out;

  tscd_front #(
    .ADC_RANGE(ADC_RANGE)
  ) u_front (
    .kind_i  (kind_i),
    .knob_a_i(knob_a_i),
    .knob_b_i(knob_b_i),
    .knob_c_i(knob_c_i),
    .item_o  (front_item)
  );

  tscd_fifo #(
    .WIDTH($bits(tscd_item_t)),
    .DEPTH(2)
  ) u_item_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_item),
    .full_o (full),
    .pop_i  (item_pop),
    .data_o (back_item),
    .empty_o(item_empty)
  );

  tscd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (back_item),
    .item_empty_i(item_empty),
    .item_pop_o  (item_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  tscd_fifo #(
    .WIDTH(3),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign out_a_o = res_out[GEN_A];
  assign out_b_o = res_out[GEN_B];
  assign out_c_o = res_out[GEN_C];

endmodule

// File: bench/tb_triple_synced_clock_divider_core.sv
// Self-checking bench for triple_synced_clock_divider_core: streams tick and knob
// transactions and compares every output-level result with an in-bench prediction.
// Depends on tscd_pkg and the core RTL.
module tb_triple_synced_clock_divider_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tscd_pkg::*;

  localparam int unsigned ADC_SPAN      = 1024;
  localparam int unsigned RATE_DIVIDEND = 8160 * 1000 / 48;
  localparam int unsigned RATE_OFFSET   = 666;
  localparam int unsigned LAST_INDEX    = 10;
  localparam int unsigned DUTY_CAP      = 6;
  // A generator step needs over a hundred ticks, so ticks dominate the random stream.
  localparam int unsigned NUM_RANDOM    = 580;
  localparam int unsigned KNOB_ODDS     = 400;
  localparam int unsigned DRAIN_CYCLES  = 32;
  localparam int unsigned CYCLE_LIMIT   = 8000000;
  localparam int unsigned TICKS_B [11] = '{288, 240, 192, 144, 96, 48, 24, 16, 12, 9, 8};
  localparam int unsigned TICKS_C [11] = '{1152, 768, 384, 192, 96, 48, 24, 12, 6, 3, 2};

  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } levels_t;

  class levels_scoreboard;
    logic [15:0] master_count;
    logic [15:0] master_period;
    logic [15:0] position [3];
    logic [10:0] wrap_at [3];
    logic [2:0]  duty [3];
    logic        level [3];
    logic [3:0]  sel_b;
    logic [3:0]  sel_c;
    logic [1:0]  resync;
    levels_t     expected_levels [$];
    int unsigned mismatches;

    function new();
      master_count  = '0;
      master_period = '0;
      for (int g = 0; g < 3; g++) begin
        position[g] = '0;
        wrap_at[g]  = '0;
        duty[g]     = '0;
        level[g]    = 1'b1;
      end
      wrap_at[GEN_A] = 11'd47;
      duty[GEN_A]    = 3'd6;
      sel_b          = 4'd5;
      sel_c          = 4'd5;
      resync         = '0;
      mismatches     = 0;
    endfunction

    // Flagged generators restart on the A on-edge; their own step then lands on 0.
    function void apply_resync();
      if (resync[0]) begin
        position[GEN_B] = 16'hFFFF;
        level[GEN_B]    = 1'b1;
      end
      if (resync[1]) begin
        position[GEN_C] = 16'hFFFF;
        level[GEN_C]    = 1'b1;
      end
      resync = '0;
    endfunction

    function void step_gen(int unsigned g);
      position[g] = position[g] + 16'd1;
      if (position[g] == 16'(duty[g])) level[g] = 1'b0;
      if (position[g] > 16'(wrap_at[g])) begin
        position[g] = '0;
        level[g]    = 1'b1;
        if (g == GEN_A) apply_resync();
      end
    endfunction

    function logic [3:0] table_index(logic [9:0] knob);
      int unsigned idx;
      idx = int'(knob) * 11 / ADC_SPAN;
      if (idx > LAST_INDEX) idx = LAST_INDEX;
      return 4'(idx);
    endfunction

    function void set_length(int unsigned g, int unsigned ticks);
      int unsigned half;
      half       = ticks >> 1;
      duty[g]    = 3'((half < DUTY_CAP) ? half : DUTY_CAP);
      wrap_at[g] = 11'(ticks - 1);
    endfunction

    function void note_item(kind_e kind, logic [9:0] knob_a, logic [9:0] knob_b,
                            logic [9:0] knob_c);
      logic [3:0]  idx_b;
      logic [3:0]  idx_c;
      int unsigned divisor;
      if (kind == KIND_TICK) begin
        master_count = master_count + 16'd1;
        if (master_count > master_period) begin
          master_count = '0;
          step_gen(GEN_A);
          step_gen(GEN_B);
          step_gen(GEN_C);
        end
      end else begin
        idx_b = table_index(knob_b);
        idx_c = table_index(knob_c);
        divisor = int'(knob_a) * 2 / 3 + RATE_OFFSET;
        if (idx_b != sel_b) begin
          sel_b     = idx_b;
          resync[0] = 1'b1;
        end
        if (idx_c != sel_c) begin
          sel_c     = idx_c;
          resync[1] = 1'b1;
        end
        master_period = 16'(RATE_DIVIDEND / divisor);
        set_length(GEN_B, TICKS_B[idx_b]);
        set_length(GEN_C, TICKS_C[idx_c]);
      end
      expected_levels.push_back({level[GEN_A], level[GEN_B], level[GEN_C]});
    endfunction

    function void compare_field(string field, logic want, logic got);
      if (want !== got) begin
        mismatches++;
        $error("%s: expected %0b, actual %0b", field, want, got);
      end
    endfunction

    function void check_levels(levels_t got);
      levels_t want;
      if (expected_levels.size() == 0) begin
        mismatches++;
        $error("unexpected result: out_a %0b out_b %0b out_c %0b", got.a, got.b, got.c);
        return;
      end
      want = expected_levels.pop_front();
      compare_field("out_a", want.a, got.a);
      compare_field("out_b", want.b, got.b);
      compare_field("out_c", want.c, got.c);
    endfunction

    function int unsigned pending();
      return expected_levels.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic       kind_i;
  logic [9:0] knob_a_i;
  logic [9:0] knob_b_i;
  logic [9:0] knob_c_i;
  logic       pop;
  logic       empty;
  logic       out_a_o;
  logic       out_b_o;
  logic       out_c_o;

  levels_scoreboard board;
  int unsigned      cycle_count;
  int unsigned      stretch_left [2];
  bit               stretch_calm [2];

  triple_synced_clock_divider_core #(
    .ADC_RANGE(ADC_SPAN)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .kind_i  (kind_i),
    .knob_a_i(knob_a_i),
    .knob_b_i(knob_b_i),
    .knob_c_i(knob_c_i),
    .pop     (pop),
    .empty   (empty),
    .out_a_o (out_a_o),
    .out_b_o (out_b_o),
    .out_c_o (out_c_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Side 0 is the sender, side 1 the receiver; each stretch is randomly calm or jittery.
  function automatic int unsigned draw_gap(int side);
    if (stretch_left[side] == 0) begin
      stretch_left[side] = $urandom_range(10, 150);
      stretch_calm[side] = $urandom_range(0, 1);
    end
    stretch_left[side]--;
    return stretch_calm[side] ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_item(kind_e kind, logic [9:0] knob_a, logic [9:0] knob_b,
                           logic [9:0] knob_c);
    int unsigned gap;
    gap = draw_gap(0);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push     <= 1'b1;
    kind_i   <= kind;
    knob_a_i <= knob_a;
    knob_b_i <= knob_b;
    knob_c_i <= knob_c;
    do @(posedge clk_i); while (full);
    board.note_item(kind, knob_a, knob_b, knob_c);
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, 10'($urandom), 10'($urandom), 10'($urandom));
  endtask

  initial begin
    int unsigned gap;
    pop = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = draw_gap(1);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      board.check_levels({out_a_o, out_b_o, out_c_o});
    end
  end

  initial begin
    board       = new();
    cycle_count = 0;
    push        = 1'b0;
    kind_i      = KIND_TICK;
    knob_a_i    = '0;
    knob_b_i    = '0;
    knob_c_i    = '0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Period is zero out of reset, so every tick steps all three generators.
    repeat (6) send_item(KIND_TICK, 10'h3FF, 10'h3FF, 10'h3FF);
    // Same table index as reset: no resync requested.
    send_item(KIND_KNOB, 10'd466, 10'd466, 10'd466);
    repeat (3) send_tick();
    send_item(KIND_KNOB, 10'd0, 10'd0, 10'd0);
    send_item(KIND_KNOB, 10'h3FF, 10'h3FF, 10'h3FF);
    // Index boundaries: 93/94 straddle 0/1, 930/931 straddle 9/10.
    send_item(KIND_KNOB, 10'd93, 10'd94, 10'd93);
    send_item(KIND_KNOB, 10'd1, 10'd930, 10'd931);
    repeat (6) send_item(KIND_TICK, 10'd0, 10'd0, 10'd0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if ($urandom_range(1, KNOB_ODDS) == 1)
        send_item(KIND_KNOB, 10'($urandom), 10'($urandom), 10'($urandom));
      else
        send_tick();
    end
    push <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
